FILE: hw/rtl/mfpt_pkg.sv
// Shared types and constants of the monochrome framebuffer page transposer.
`default_nettype none

package mfpt_pkg;

  // Item kinds on the input channel.
  localparam logic KIND_WRITE = 1'b0;
  localparam logic KIND_READ  = 1'b1;

  // Width of the linear byte index before range checks (row * groups + group).
  localparam int unsigned IDX_W = 13;

  // Sequencer states, one-hot.
  typedef enum logic [4:0] {
    ST_CLEAR  = 5'b00001,
    ST_IDLE   = 5'b00010,
    ST_READ   = 5'b00100,
    ST_LAST   = 5'b01000,
    ST_FINISH = 5'b10000
  } state_e;

endpackage

`default_nettype wire

FILE: hw/rtl/mfpt_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
`default_nettype none

module mfpt_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 1024,
  localparam int unsigned AddrW = $clog2(DEPTH)
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AddrW-1:0] waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AddrW-1:0] raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

FILE: hw/rtl/mono_framebuffer_page_transposer_unit.sv
// Top level: monochrome framebuffer with LCD page-format column readout.
//
//   Channel | Direction | Handshake                  | Payload
//   --------+-----------+----------------------------+--------------------------------------
//   in      | into      | in_valid_i / in_stall_o    | kind, row, column_group, pixels,
//           |           |                            | end_of_frame, page, column
//   out     | out of    | out_valid_o / out_stall_i  | page_byte, frame_ready
//   cfg     | into      | cfg_valid_i / cfg_ready_o  | invert_pixels
//
// A write transfer is stored at its accepting edge; its result enters the output register at
// that edge, or at the first later edge at which the held result leaves.
// A read transfer gathers one bit from each of eight row bytes, one per cycle through the
// single read port, and keeps the input stalled until its result enters the output register.
// After reset a clearing pass zeroes all (DISPLAY_WIDTH/8)*DISPLAY_HEIGHT bytes (1024 by
// default) with the input stalled. A held result stalls a second one until it leaves.
`default_nettype none

module mono_framebuffer_page_transposer_unit #(
  parameter int unsigned DISPLAY_WIDTH  = 128,
  parameter int unsigned DISPLAY_HEIGHT = 64
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,

  input  wire logic       in_valid_i,
  output logic            in_stall_o,
  input  wire logic       in_kind_i,
  input  wire logic [5:0] in_row_i,
  input  wire logic [3:0] in_column_group_i,
  input  wire logic [7:0] in_pixels_i,
  input  wire logic       in_end_of_frame_i,
  input  wire logic [2:0] in_page_i,
  input  wire logic [6:0] in_column_i,

  output logic            out_valid_o,
  input  wire logic       out_stall_i,
  output logic      [7:0] out_page_byte_o,
  output logic            out_frame_ready_o,

  input  wire logic       cfg_valid_i,
  output logic            cfg_ready_o,
  input  wire logic       cfg_invert_pixels_i
);

  // Geometry derived from the display size.
  localparam int unsigned Groups    = DISPLAY_WIDTH / 8;
  localparam int unsigned Depth     = Groups * DISPLAY_HEIGHT;
  localparam int unsigned AddrW     = $clog2(Depth);
  localparam int unsigned IdxW      = mfpt_pkg::IDX_W;
  localparam logic [7:0]  HeightV   = 8'(DISPLAY_HEIGHT);
  localparam logic [8:0]  WidthV    = 9'(DISPLAY_WIDTH);
  localparam logic [5:0]  GroupsV   = 6'(Groups);
  localparam logic [IdxW-1:0] DepthV = IdxW'(Depth);
  localparam logic [3:0]  LastPageV = 4'((DISPLAY_HEIGHT + 7) / 8 - 1);
  localparam logic [7:0]  LastColV  = 8'(DISPLAY_WIDTH - 1);
  localparam logic [AddrW-1:0] LastAddrV = AddrW'(Depth - 1);

  mfpt_pkg::state_e state_q, state_d;

  logic             invert_q;
  logic             flag_q, flag_d;
  logic [AddrW-1:0] clr_q, clr_d;
  logic [2:0]       cnt_q, cnt_d;
  logic [2:0]       page_q, page_d;
  logic [6:0]       col_q, col_d;
  logic [7:0]       byte_q;
  logic             res_ready_q, res_ready_d;

  // Read data bookkeeping, registered with the memory read request for the cycle after it.
  logic             rd_vld_q;
  logic [2:0]       rd_k_q;
  logic             rd_ok_q;
  logic [2:0]       rd_sel_q;

  logic             out_valid_q, out_valid_d;
  logic [7:0]       out_byte_q, out_byte_d;
  logic             out_ready_q, out_ready_d;

  logic             accept;
  logic             out_free;
  logic             write_acc;
  logic             read_acc;
  logic             last_pos;

  // Address path shared by writes and read issue.
  logic [5:0]       acc_row;
  logic [3:0]       acc_group;
  logic             acc_in_pic;
  logic [IdxW-1:0]  acc_idx;
  logic             acc_ok;
  logic [AddrW-1:0] acc_addr;

  logic             mem_we;
  logic [AddrW-1:0] mem_waddr;
  logic [7:0]       mem_wdata;
  logic             mem_re;
  logic [7:0]       mem_rdata;

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = (state_q != mfpt_pkg::ST_IDLE);
  assign accept      = in_valid_i && !in_stall_o;
  assign write_acc   = accept && (in_kind_i == mfpt_pkg::KIND_WRITE);
  assign read_acc    = accept && (in_kind_i == mfpt_pkg::KIND_READ);
  assign out_free    = !out_valid_q || !out_stall_i;
  assign last_pos    = ({1'b0, in_page_i} == LastPageV) && ({1'b0, in_column_i} == LastColV);

  // In idle the address comes from the write fields; while reading, from the held page and
  // column with the row step counter selecting one of the page's eight rows.
  always_comb begin
    if (state_q == mfpt_pkg::ST_READ) begin
      acc_row    = {page_q, cnt_q};
      acc_group  = col_q[6:3];
      acc_in_pic = ({2'b00, acc_row} < HeightV) && ({2'b00, col_q} < WidthV);
    end else begin
      acc_row    = in_row_i;
      acc_group  = in_column_group_i;
      acc_in_pic = ({2'b00, acc_row} < HeightV) && ({2'b00, acc_group} < GroupsV);
    end
    acc_idx  = IdxW'(acc_row) * IdxW'(Groups) + IdxW'(acc_group);
    acc_ok   = acc_in_pic && (acc_idx < DepthV);
    acc_addr = acc_ok ? AddrW'(acc_idx) : '0;
  end

  // Memory port control: the clearing pass owns the write port after reset.
  always_comb begin
    if (state_q == mfpt_pkg::ST_CLEAR) begin
      mem_we    = 1'b1;
      mem_waddr = clr_q;
      mem_wdata = '0;
    end else begin
      mem_we    = write_acc && acc_ok;
      mem_waddr = acc_addr;
      mem_wdata = in_pixels_i ^ {8{invert_q}};
    end
    mem_re = (state_q == mfpt_pkg::ST_READ);
  end

  // Sequencer.
  always_comb begin
    state_d     = state_q;
    flag_d      = flag_q;
    clr_d       = clr_q;
    cnt_d       = cnt_q;
    page_d      = page_q;
    col_d       = col_q;
    res_ready_d = res_ready_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_byte_d  = out_byte_q;
    out_ready_d = out_ready_q;

    unique case (state_q)
      mfpt_pkg::ST_CLEAR: begin
        clr_d = clr_q + 1'b1;
        if (clr_q == LastAddrV) begin
          state_d = mfpt_pkg::ST_IDLE;
        end
      end
      mfpt_pkg::ST_IDLE: begin
        if (write_acc) begin
          flag_d = flag_q || in_end_of_frame_i;
          if (out_free) begin
            out_valid_d = 1'b1;
            out_byte_d  = '0;
            out_ready_d = flag_d;
          end else begin
            res_ready_d = flag_d;
            state_d     = mfpt_pkg::ST_FINISH;
          end
        end else if (read_acc) begin
          // The flag is reported as it stood before the read; the clearing read drops it
          // right away since no other item runs until this one finishes.
          res_ready_d = flag_q;
          if (last_pos) begin
            flag_d = 1'b0;
          end
          page_d  = in_page_i;
          col_d   = in_column_i;
          cnt_d   = '0;
          state_d = mfpt_pkg::ST_READ;
        end
      end
      mfpt_pkg::ST_READ: begin
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == 3'd7) begin
          state_d = mfpt_pkg::ST_LAST;
        end
      end
      mfpt_pkg::ST_LAST: begin
        state_d = mfpt_pkg::ST_FINISH;
      end
      mfpt_pkg::ST_FINISH: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_byte_d  = byte_q;
          out_ready_d = res_ready_q;
          state_d     = mfpt_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = mfpt_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= mfpt_pkg::ST_CLEAR;
      invert_q    <= 1'b0;
      flag_q      <= 1'b0;
      clr_q       <= '0;
      cnt_q       <= '0;
      rd_vld_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      flag_q      <= flag_d;
      clr_q       <= clr_d;
      cnt_q       <= cnt_d;
      rd_vld_q    <= mem_re;
      out_valid_q <= out_valid_d;
      if (cfg_valid_i && cfg_ready_o) begin
        invert_q <= cfg_invert_pixels_i;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    page_q      <= page_d;
    col_q       <= col_d;
    res_ready_q <= res_ready_d;
    out_byte_q  <= out_byte_d;
    out_ready_q <= out_ready_d;
    rd_k_q      <= cnt_q;
    rd_ok_q     <= acc_ok;
    rd_sel_q    <= col_q[2:0];
    if (write_acc && !out_free) begin
      byte_q <= '0;
    end else if (rd_vld_q) begin
      // Leftmost pixel sits in the MSB of a stored byte.
      byte_q[rd_k_q] <= rd_ok_q && mem_rdata[3'd7 - rd_sel_q];
    end
  end

  mfpt_ram #(
    .WIDTH (8),
    .DEPTH (Depth)
  ) u_pixel_store (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (acc_addr),
    .rdata_o (mem_rdata)
  );

  assign out_valid_o       = out_valid_q;
  assign out_page_byte_o   = out_byte_q;
  assign out_frame_ready_o = out_ready_q;

  // The state register always carries exactly one active code.
  a_state_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot(state_q))
    else $error("sequencer state is not one-hot");

  // No memory write may land while a read sequence is gathering row bytes.
  a_no_write_in_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == mfpt_pkg::ST_READ || state_q == mfpt_pkg::ST_LAST) |-> !mem_we)
    else $error("memory written during a read sequence");

  // Row data is only collected in the cycle after a read request.
  a_read_data_timing: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_vld_q |-> $past(state_q) == mfpt_pkg::ST_READ)
    else $error("row data collected without a preceding read request");

  // A read of the last page and column leaves the frame flag cleared.
  a_clearing_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (read_acc && last_pos) |=> !flag_q)
    else $error("clearing read did not drop the frame flag");

  // A write marked end of frame leaves the frame flag set.
  a_eof_sets_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (write_acc && in_end_of_frame_i) |=> flag_q)
    else $error("end-of-frame write did not set the frame flag");

endmodule

`default_nettype wire

FILE: tb/mono_framebuffer_page_transposer_unit_test.sv
// Self-checking testbench of the monochrome framebuffer page transposer.
`timescale 1ns / 1ps

module mono_framebuffer_page_transposer_unit_test;

  // Display size of the block under test (the defaults of the top level).
  localparam int unsigned DISPLAY_WIDTH  = 128;
  localparam int unsigned DISPLAY_HEIGHT = 64;
  localparam int unsigned GROUPS_PER_ROW = DISPLAY_WIDTH / 8;
  localparam int unsigned STORE_BYTES    = GROUPS_PER_ROW * DISPLAY_HEIGHT;
  localparam int unsigned LAST_PAGE      = (DISPLAY_HEIGHT + 7) / 8 - 1;
  localparam int unsigned LAST_COLUMN    = DISPLAY_WIDTH - 1;

  // Items per random phase; six phases give about 1500 items.
  localparam int unsigned PHASE_ITEMS  = 250;
  localparam int unsigned NUM_PHASES   = 6;
  // The long receiver hold-off starts once this many items went in.
  localparam int unsigned HOLD_AFTER   = 300;
  localparam int unsigned HOLD_CYCLES  = 400;
  // Cycles to let pass after the last result.
  localparam int unsigned SETTLE_CYCLES = 40;
  // Mismatch lines printed at most, to keep the log readable.
  localparam int unsigned MAX_REPORTS  = 100;

  // One input item, one field per port.
  typedef struct packed {
    logic       kind;
    logic [5:0] row;
    logic [3:0] column_group;
    logic [7:0] pixels;
    logic       end_of_frame;
    logic [2:0] page;
    logic [6:0] column;
  } fb_item_t;

  // One result item.
  typedef struct packed {
    logic [7:0] page_byte;
    logic       frame_ready;
  } fb_result_t;

  // A row of the directed table. A negative invert_before leaves the register alone;
  // otherwise the register is written with that value before the item goes in.
  typedef struct {
    int         invert_before;
    fb_item_t   item;
    bit         golden;
    fb_result_t result;
  } dir_row_t;

  // Clock and reset.
  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  always #5 clk_i = ~clk_i;

  // Every input of the block starts at a known value.
  logic       in_valid_i          = 1'b0;
  logic       in_kind_i           = 1'b0;
  logic [5:0] in_row_i            = '0;
  logic [3:0] in_column_group_i   = '0;
  logic [7:0] in_pixels_i         = '0;
  logic       in_end_of_frame_i   = 1'b0;
  logic [2:0] in_page_i           = '0;
  logic [6:0] in_column_i         = '0;
  logic       out_stall_i         = 1'b0;
  logic       cfg_valid_i         = 1'b0;
  logic       cfg_invert_pixels_i = 1'b0;

  logic       in_stall_o;
  logic       out_valid_o;
  logic [7:0] out_page_byte_o;
  logic       out_frame_ready_o;
  logic       cfg_ready_o;

  mono_framebuffer_page_transposer_unit #(
    .DISPLAY_WIDTH  (DISPLAY_WIDTH),
    .DISPLAY_HEIGHT (DISPLAY_HEIGHT)
  ) i_dut (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .in_valid_i          (in_valid_i),
    .in_stall_o          (in_stall_o),
    .in_kind_i           (in_kind_i),
    .in_row_i            (in_row_i),
    .in_column_group_i   (in_column_group_i),
    .in_pixels_i         (in_pixels_i),
    .in_end_of_frame_i   (in_end_of_frame_i),
    .in_page_i           (in_page_i),
    .in_column_i         (in_column_i),
    .out_valid_o         (out_valid_o),
    .out_stall_i         (out_stall_i),
    .out_page_byte_o     (out_page_byte_o),
    .out_frame_ready_o   (out_frame_ready_o),
    .cfg_valid_i         (cfg_valid_i),
    .cfg_ready_o         (cfg_ready_o),
    .cfg_invert_pixels_i (cfg_invert_pixels_i)
  );

  // Shadow copy of the framebuffer, the frame-ready flag and the invert register.
  // A bit array starts at zero, which matches the cleared memory after reset.
  bit [7:0]   shadow_fb [0:STORE_BYTES-1];
  bit         shadow_pending;
  bit         shadow_invert;

  // Results still owed by the block, oldest first.
  fb_result_t owed_results [$];
  fb_result_t oldest_result;

  dir_row_t   directed_rows [$];

  int unsigned error_count    = 0;
  int unsigned accepted_count = 0;
  // Sender pacing: items left in the current burst, and whether gaps are off.
  int unsigned burst_left     = 0;
  bit          steady         = 1'b0;

  // Applies one item to the shadow state and returns the result the block must give.
  function automatic fb_result_t apply_item(input fb_item_t it);
    fb_result_t res;
    int unsigned r;
    res.page_byte   = '0;
    res.frame_ready = shadow_pending;
    if (it.kind == mfpt_pkg::KIND_WRITE) begin
      // Pixels land in the row-major store, complemented when inversion is on.
      if (it.row < DISPLAY_HEIGHT && it.column_group < GROUPS_PER_ROW) begin
        shadow_fb[it.row * GROUPS_PER_ROW + it.column_group] =
          shadow_invert ? ~it.pixels : it.pixels;
      end
      if (it.end_of_frame) begin
        shadow_pending = 1'b1;
      end
      res.frame_ready = shadow_pending;
    end else begin
      // Bit k of the page byte is the pixel of row 8*page+k in this column;
      // the leftmost pixel of a stored byte sits in its MSB.
      for (int k = 0; k < 8; k++) begin
        r = it.page * 8 + k;
        if (r < DISPLAY_HEIGHT && it.column < DISPLAY_WIDTH) begin
          res.page_byte[k] = shadow_fb[r * GROUPS_PER_ROW + (it.column >> 3)][7 - it.column[2:0]];
        end
      end
      // The flag is reported as it stood, then the last column of the last page clears it.
      res.frame_ready = shadow_pending;
      if (it.page == LAST_PAGE && it.column == LAST_COLUMN) begin
        shadow_pending = 1'b0;
      end
    end
    return res;
  endfunction

  // An item with every field random, the unused ones included.
  function automatic fb_item_t random_item();
    fb_item_t it;
    it.kind         = 1'($urandom_range(0, 1));
    it.row          = 6'($urandom_range(0, 63));
    it.column_group = 4'($urandom_range(0, 15));
    it.pixels       = 8'($urandom_range(0, 255));
    it.end_of_frame = 1'($urandom_range(0, 1));
    it.page         = 3'($urandom_range(0, 7));
    it.column       = 7'($urandom_range(0, 127));
    return it;
  endfunction

  task automatic add_row(input int inv, input bit kind, input int row, input int group,
                         input int pixels, input bit eof, input int page, input int column,
                         input bit golden, input int page_byte, input bit frame_ready);
    dir_row_t dr;
    dr.invert_before          = inv;
    dr.item.kind              = kind;
    dr.item.row               = 6'(row);
    dr.item.column_group      = 4'(group);
    dr.item.pixels            = 8'(pixels);
    dr.item.end_of_frame      = eof;
    dr.item.page              = 3'(page);
    dr.item.column            = 7'(column);
    dr.golden                 = golden;
    dr.result.page_byte       = 8'(page_byte);
    dr.result.frame_ready     = frame_ready;
    directed_rows.push_back(dr);
  endtask

  // Offers one item and waits for its transfer. It must be called at a rising edge.
  // Valid stays high into the next item within a burst, so it is only lowered for a gap.
  task automatic offer_item(input fb_item_t it, input bit golden, input fb_result_t gold);
    fb_result_t predicted;
    int unsigned gap;
    in_valid_i        <= 1'b1;
    in_kind_i         <= it.kind;
    in_row_i          <= it.row;
    in_column_group_i <= it.column_group;
    in_pixels_i       <= it.pixels;
    in_end_of_frame_i <= it.end_of_frame;
    in_page_i         <= it.page;
    in_column_i       <= it.column;
    do @(posedge clk_i); while (!(in_valid_i && !in_stall_o));
    // The shadow state always advances; a typed-in result takes the place of the prediction.
    predicted = apply_item(it);
    owed_results.push_back(golden ? gold : predicted);
    accepted_count++;
    if (steady || burst_left > 0) begin
      if (burst_left > 0) begin
        burst_left--;
      end
    end else begin
      gap = $urandom_range(1, 8);
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
      burst_left = $urandom_range(0, 20);
    end
  endtask

  // Writes the invert register once every owed result has come back.
  task automatic write_invert(input bit value);
    in_valid_i <= 1'b0;
    while (owed_results.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    cfg_valid_i         <= 1'b1;
    cfg_invert_pixels_i <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    shadow_invert = value;
    cfg_valid_i <= 1'b0;
  endtask

  // Result checker: every result transfer is matched against the oldest owed result.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (owed_results.size() == 0) begin
        error_count++;
        if (error_count <= MAX_REPORTS) begin
          $display("%0t: result transfer with none owed: page_byte %02h frame_ready %0b",
                   $time, out_page_byte_o, out_frame_ready_o);
        end
      end else begin
        oldest_result = owed_results.pop_front();
        if (out_page_byte_o !== oldest_result.page_byte) begin
          error_count++;
          if (error_count <= MAX_REPORTS) begin
            $display("%0t: page_byte mismatch: expected %02h, actual %02h",
                     $time, oldest_result.page_byte, out_page_byte_o);
          end
        end
        if (out_frame_ready_o !== oldest_result.frame_ready) begin
          error_count++;
          if (error_count <= MAX_REPORTS) begin
            $display("%0t: frame_ready mismatch: expected %0b, actual %0b",
                     $time, oldest_result.frame_ready, out_frame_ready_o);
          end
        end
      end
    end
  end

  // Receiver: stalls in segments of changing character, and once holds off for a long
  // stretch while the sender keeps offering, so that the block fills up and stalls its input.
  initial begin : receiver
    int unsigned seg_left;
    int unsigned mode;
    bit          held;
    seg_left = 0;
    mode     = 0;
    held     = 1'b0;
    forever begin
      @(posedge clk_i);
      if (!held && accepted_count >= HOLD_AFTER) begin
        held = 1'b1;
        out_stall_i <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk_i);
      end else begin
        if (seg_left == 0) begin
          seg_left = $urandom_range(10, 60);
          mode     = $urandom_range(0, 3);
        end
        seg_left--;
        case (mode)
          0: begin
            out_stall_i <= 1'b0;
          end
          1: begin
            out_stall_i <= ($urandom_range(0, 3) == 0);
          end
          2: begin
            out_stall_i <= ($urandom_range(0, 3) != 0);
          end
          default: begin
            out_stall_i <= ~out_stall_i;
          end
        endcase
      end
    end
  end

  // Stimulus: directed table first, then random phases with the register changed in between.
  initial begin : stimulus
    fb_item_t    it;
    fb_result_t  no_result;
    int unsigned pick;
    int unsigned n;
    int unsigned start;
    int unsigned pg;
    int unsigned phase_items;
    bit          invert_value;

    no_result = '0;

    // Directed rows. Typed-in results are the ones that follow plainly from reset
    // and the extremes; the rest come from the shadow model.
    // Reads right after reset see the cleared memory and no frame waiting.
    add_row(-1, mfpt_pkg::KIND_READ,   0,  0, 8'h00, 0, 0,   0, 1, 8'h00, 0);
    // Clearing read while the flag is already clear.
    add_row(-1, mfpt_pkg::KIND_READ,   0,  0, 8'h00, 0, 7, 127, 1, 8'h00, 0);
    // Writes at the first and the last byte of the picture.
    add_row(-1, mfpt_pkg::KIND_WRITE,  0,  0, 8'hFF, 0, 0,   0, 1, 8'h00, 0);
    add_row(-1, mfpt_pkg::KIND_WRITE, 63, 15, 8'h80, 0, 0,   0, 1, 8'h00, 0);
    add_row(-1, mfpt_pkg::KIND_READ,   0,  0, 8'h00, 0, 0,   0, 1, 8'h01, 0);
    add_row(-1, mfpt_pkg::KIND_READ,   0,  0, 8'h00, 0, 0,   7, 1, 8'h01, 0);
    add_row(-1, mfpt_pkg::KIND_READ,   0,  0, 8'h00, 0, 7, 120, 1, 8'h80, 0);
    // End of frame sets the flag; the clearing read still reports it, the next does not.
    add_row(-1, mfpt_pkg::KIND_WRITE,  1,  0, 8'h00, 1, 0,   0, 1, 8'h00, 1);
    add_row(-1, mfpt_pkg::KIND_READ,   0,  0, 8'h00, 0, 0,   0, 1, 8'h01, 1);
    add_row(-1, mfpt_pkg::KIND_READ,   0,  0, 8'h00, 0, 7, 127, 1, 8'h00, 1);
    add_row(-1, mfpt_pkg::KIND_READ,   0,  0, 8'h00, 0, 0,   0, 1, 8'h01, 0);
    // Fields of the other kind are ignored: a write aimed at the clearing column,
    // and a read carrying an end-of-frame mark.
    add_row(-1, mfpt_pkg::KIND_WRITE,  2,  3, 8'hA5, 0, 7, 127, 0, 8'h00, 0);
    add_row(-1, mfpt_pkg::KIND_READ,  63, 15, 8'hFF, 1, 0,  24, 0, 8'h00, 0);
    add_row(-1, mfpt_pkg::KIND_WRITE, 37,  9, 8'h5A, 1, 0,   0, 0, 8'h00, 0);
    add_row(-1, mfpt_pkg::KIND_READ,   0,  0, 8'h00, 0, 4,  73, 0, 8'h00, 0);
    // Inverted writes.
    add_row( 1, mfpt_pkg::KIND_WRITE,  8,  1, 8'h0F, 0, 0,   0, 0, 8'h00, 0);
    add_row(-1, mfpt_pkg::KIND_READ,   0,  0, 8'h00, 0, 1,   8, 0, 8'h00, 0);
    add_row(-1, mfpt_pkg::KIND_WRITE, 15,  1, 8'hFF, 0, 0,   0, 0, 8'h00, 0);
    add_row(-1, mfpt_pkg::KIND_READ,   0,  0, 8'h00, 0, 1,  15, 0, 8'h00, 0);
    add_row(-1, mfpt_pkg::KIND_READ,   0,  0, 8'h00, 0, 7, 127, 0, 8'h00, 0);
    // Back to plain writes.
    add_row( 0, mfpt_pkg::KIND_WRITE, 63, 15, 8'hFF, 1, 0,   0, 0, 8'h00, 0);
    add_row(-1, mfpt_pkg::KIND_READ,   0,  0, 8'h00, 0, 7, 127, 0, 8'h00, 0);
    add_row(-1, mfpt_pkg::KIND_WRITE,  0,  0, 8'h00, 0, 0,   0, 0, 8'h00, 0);
    add_row(-1, mfpt_pkg::KIND_READ,   0,  0, 8'h00, 0, 0,   0, 0, 8'h00, 0);

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // The register is written once right after reset; its port is always ready.
    write_invert(1'b0);

    foreach (directed_rows[i]) begin
      if (directed_rows[i].invert_before >= 0) begin
        write_invert(directed_rows[i].invert_before[0]);
      end
      offer_item(directed_rows[i].item, directed_rows[i].golden, directed_rows[i].result);
    end

    for (int phase = 0; phase < NUM_PHASES; phase++) begin
      // Both register values come up early; later phases pick at random.
      if (phase < 2) begin
        invert_value = (phase == 0);
      end else begin
        invert_value = 1'($urandom_range(0, 1));
      end
      write_invert(invert_value);
      // One phase runs with no gaps on the sender side.
      steady = (phase == 3);
      phase_items = 0;
      while (phase_items < PHASE_ITEMS) begin
        pick = $urandom_range(0, 99);
        if (pick < 40) begin
          // Frame flush: a run of writes, the last one usually carrying an end-of-frame mark.
          n = $urandom_range(1, 12);
          for (int i = 0; i < n; i++) begin
            it = random_item();
            it.kind = mfpt_pkg::KIND_WRITE;
            it.end_of_frame = (i == n - 1) ? ($urandom_range(0, 3) != 0) : 1'b0;
            offer_item(it, 1'b0, no_result);
          end
        end else if (pick < 75) begin
          // Page readout: consecutive columns of one page, now and then running
          // into the last column of the last page.
          n = $urandom_range(1, 16);
          if ($urandom_range(0, 3) == 0) begin
            pg    = LAST_PAGE;
            start = DISPLAY_WIDTH - n;
          end else begin
            pg    = $urandom_range(0, 7);
            start = $urandom_range(0, DISPLAY_WIDTH - n);
          end
          for (int i = 0; i < n; i++) begin
            it = random_item();
            it.kind   = mfpt_pkg::KIND_READ;
            it.page   = 3'(pg);
            it.column = 7'(start + i);
            offer_item(it, 1'b0, no_result);
          end
        end else if (pick < 85) begin
          // A lone clearing read.
          n = 1;
          it = random_item();
          it.kind   = mfpt_pkg::KIND_READ;
          it.page   = 3'(LAST_PAGE);
          it.column = 7'(LAST_COLUMN);
          offer_item(it, 1'b0, no_result);
        end else begin
          // Noise: one fully random item.
          n = 1;
          offer_item(random_item(), 1'b0, no_result);
        end
        phase_items += n;
      end
    end

    // Drain: wait for every owed result, then watch a while for stray transfers.
    steady = 1'b0;
    in_valid_i <= 1'b0;
    while (owed_results.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);

    if (error_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest correct run, clearing pass and long hold-off included.
  initial begin : watchdog
    #5_000_000;
    $display("Test completed with failures");
    $finish;
  end

endmodule
